// ----- sv/gdv_pkg.sv -----
// Shared types, constants and field formats for the geohash delta varint encoder.
`timescale 1ns / 1ps

package gdv_pkg;

    // Fixed-point format of the incoming fractions.
    localparam int FRACTION_BITS = 32;
    localparam int FIELD_BITS    = 32;
    localparam int FIELD_IDX_W   = $clog2(FIELD_BITS);

    // Geohash code geometry.
    localparam int CHAR_BITS      = 5;
    localparam int MAX_CHARS      = 11;
    localparam int CODE_BITS      = CHAR_BITS * MAX_CHARS;
    localparam int SHIFT_W        = $clog2(CODE_BITS + 1);
    localparam int CHARS_W        = 4;
    localparam logic [CHARS_W-1:0] CHARS_RESET = CHARS_W'(MAX_CHARS);
    localparam logic [CHARS_W-1:0] CHARS_MIN   = CHARS_W'(1);

    // Delta and byte formats.
    localparam int DELTA_BITS    = CODE_BITS + 1;
    localparam int ENTRY_BITS    = 64;
    localparam int FULL_BYTES    = 8;
    localparam int BYTE_CNT_W    = $clog2(FULL_BYTES);
    localparam logic [7:0] HEADER_BYTE = 8'h00;
    localparam logic [BYTE_CNT_W-1:0] LAST_FULL_IDX = BYTE_CNT_W'(FULL_BYTES - 1);

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes of an input word.
    localparam logic OP_ENCODE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Input word.
    typedef struct packed {
        logic                  op;
        logic [FIELD_BITS-1:0] lat_fraction;
        logic [FIELD_BITS-1:0] lon_fraction;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_word_t;

    // One queued point: a full first point or a zigzag delta.
    typedef struct packed {
        logic                  first;
        logic [ENTRY_BITS-1:0] data;
    } q_entry_t;

endpackage

// ----- sv/gdv_front.sv -----
// Front part: takes input words, builds the geohash code and the queued entry.
`timescale 1ns / 1ps

module gdv_front
    import gdv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CHARS_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               push_valid,
    input  logic               push_ready,
    output q_entry_t           push_entry
);

    logic [CHARS_W-1:0]   chars_reg;
    logic [CHARS_W-1:0]   chars_eff;
    logic [SHIFT_W-1:0]   shamt;
    logic [CODE_BITS-1:0] code_full;
    logic [CODE_BITS-1:0] code_now;

    logic                 st1_valid_reg;
    logic                 st1_op_reg;
    logic [CODE_BITS-1:0] st1_code_reg;

    logic                 awaiting_first_reg;
    logic                 awaiting_first_next;
    logic [CODE_BITS-1:0] prev_code_reg;
    logic [CODE_BITS-1:0] prev_code_next;

    logic                  s_fire;
    logic                  st2_fire;
    logic [DELTA_BITS-1:0] delta;
    logic [DELTA_BITS-1:0] zigzag;

    // Precision register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg <= CHARS_RESET;
        end else if (cfg_wr_en) begin
            chars_reg <= cfg_wr_data;
        end
    end

    // Out-of-range precision is clamped to the legal span.
    always_comb begin
        if (chars_reg < CHARS_MIN) begin
            chars_eff = CHARS_MIN;
        end else if (chars_reg > CHARS_RESET) begin
            chars_eff = CHARS_RESET;
        end else begin
            chars_eff = chars_reg;
        end
        shamt = SHIFT_W'(CODE_BITS) - SHIFT_W'(CHAR_BITS) * SHIFT_W'(chars_eff);
    end

    // Full-precision interleave, longitude on even bits from the top.
    // Fraction bits beyond the carried field read as zero.
    always_comb begin
        int pos;
        code_full = '0;
        for (int k = 0; k < CODE_BITS; k++) begin
            pos = FRACTION_BITS - 1 - k / 2;
            if (pos < FIELD_BITS) begin
                if (k % 2 == 0) begin
                    code_full[CODE_BITS-1-k] = s_data.lon_fraction[pos[FIELD_IDX_W-1:0]];
                end else begin
                    code_full[CODE_BITS-1-k] = s_data.lat_fraction[pos[FIELD_IDX_W-1:0]];
                end
            end
        end
        code_now = code_full >> shamt;
    end

    // First stage holds the accepted word with its code.
    assign s_fire   = s_valid && s_ready;
    assign st2_fire = st1_valid_reg && ((st1_op_reg == OP_RESTART) || push_ready);
    assign s_ready  = !st1_valid_reg || st2_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_op_reg   <= s_data.op;
            st1_code_reg <= code_now;
        end
    end

    // Second stage: delta against the stored code, zigzag, and state update.
    always_comb begin
        delta  = {1'b0, st1_code_reg} - {1'b0, prev_code_reg};
        zigzag = {delta[DELTA_BITS-2:0], 1'b0} ^ {DELTA_BITS{delta[DELTA_BITS-1]}};

        push_valid       = st1_valid_reg && (st1_op_reg == OP_ENCODE);
        push_entry.first = awaiting_first_reg;
        if (awaiting_first_reg) begin
            push_entry.data = {{(ENTRY_BITS - CODE_BITS - 8){1'b0}}, st1_code_reg, HEADER_BYTE};
        end else begin
            push_entry.data = {{(ENTRY_BITS - DELTA_BITS){1'b0}}, zigzag};
        end

        awaiting_first_next = awaiting_first_reg;
        prev_code_next      = prev_code_reg;
        if (st2_fire) begin
            if (st1_op_reg == OP_RESTART) begin
                awaiting_first_next = 1'b1;
                prev_code_next      = '0;
            end else begin
                awaiting_first_next = 1'b0;
                prev_code_next      = st1_code_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_first_reg <= 1'b1;
            prev_code_reg      <= '0;
        end else begin
            awaiting_first_reg <= awaiting_first_next;
            prev_code_reg      <= prev_code_next;
        end
    end

    // A restart leaves the stream waiting for a full point with a clear code.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (st2_fire && st1_op_reg == OP_RESTART) |=> (awaiting_first_reg && prev_code_reg == '0))
        else $error("restart did not clear the stream state");

    // A pushed point always ends the first-point phase and is remembered.
    a_push_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && push_ready) |=>
            (!awaiting_first_reg && prev_code_reg == $past(st1_code_reg)))
        else $error("pushed point did not update the stored code");

endmodule

// ----- sv/gdv_queue.sv -----
// Short queue of point entries between the front and back parts.
`timescale 1ns / 1ps

module gdv_queue
    import gdv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy count.
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Pointers wrap naturally at the power-of-two depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Occupancy always matches the pointer distance.
    a_count_matches_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= QCNT_W'(QUEUE_DEPTH)) &&
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg)))
        else $error("queue count and pointers disagree");

endmodule

// ----- sv/gdv_back.sv -----
// Back part: turns queued entries into output bytes, one byte per cycle while the receiver takes them.
`timescale 1ns / 1ps

module gdv_back
    import gdv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  q_entry_t  pop_entry,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  first_reg;
    logic                  first_next;
    logic [ENTRY_BITS-1:0] data_reg;
    logic [ENTRY_BITS-1:0] data_next;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic [BYTE_CNT_W-1:0] cnt_next;

    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    logic                  out_free;
    logic                  emit;
    logic                  more;
    out_word_t             cur_word;

    // Byte of the entry in hand: raw bytes for a first point, LEB128 groups otherwise.
    always_comb begin
        more = |data_reg[DELTA_BITS-1:7];
        if (first_reg) begin
            cur_word.out_byte  = data_reg[7:0];
            cur_word.last_byte = (cnt_reg == LAST_FULL_IDX);
        end else begin
            cur_word.out_byte  = {more, data_reg[6:0]};
            cur_word.last_byte = !more;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign pop_ready = !busy_reg || (emit && cur_word.last_byte);

    // Step through the entry; load the next one as soon as the last byte leaves.
    always_comb begin
        busy_next  = busy_reg;
        first_next = first_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        if (pop_ready) begin
            busy_next  = pop_valid;
            first_next = pop_entry.first;
            data_next  = pop_entry.data;
            cnt_next   = '0;
        end else if (emit) begin
            cnt_next = cnt_reg + BYTE_CNT_W'(1);
            if (first_reg) begin
                data_next = {8'b0, data_reg[ENTRY_BITS-1:8]};
            end else begin
                data_next = {7'b0, data_reg[ENTRY_BITS-1:7]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        data_reg  <= data_next;
        cnt_reg   <= cnt_next;
    end

    // Output register decouples the receiver from the byte generator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= cur_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A first point always opens with the zero header byte.
    a_header_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && first_reg && cnt_reg == '0) |-> (cur_word.out_byte == HEADER_BYTE))
        else $error("first point did not start with the header byte");

    // A delta point never runs past eight bytes.
    a_delta_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !first_reg && cnt_reg == LAST_FULL_IDX) |-> cur_word.last_byte)
        else $error("delta point longer than eight bytes");

    // A taken entry is in hand on the next cycle.
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> (busy_reg && cnt_reg == '0))
        else $error("popped entry was not loaded");

endmodule

// ----- sv/geohash_delta_varint_encoder.sv -----
// Top level of the geohash delta varint encoder.
//
// Input channel s_*: one word per point or restart (op, latitude and longitude
// fractions), valid/ready. Output channel m_*: one byte of the compressed stream
// per word, with last_byte set on the final byte of a point.
// The user writes the precision register (geohash characters) via cfg_wr_en and
// cfg_wr_data only while the block is idle (unenforced); 0 acts as 1, >11 as 11.
// A first point after reset or restart yields a zero header byte and seven code
// bytes; later points yield 1 to 8 zigzag LEB128 bytes of the code delta.
// A restart word yields no bytes and clears the stored code.
// Path: an accepted word is held in the first-stage register, then its entry
// passes through the queue and the byte generator into the output register.
// Output: the port moves one byte per cycle while the receiver is ready, with
// no gap between the bytes of queued points (8 for a first point, 1 to 8 for a
// delta); a restart is accepted like any word but takes no output slot.
// A two-entry queue sits between the code builder and the byte generator, so
// new words are accepted while earlier bytes wait; when the receiver stalls,
// the output register holds its byte and the queue fills before s_ready drops.
// Reset clears all control state, restores 11 characters and awaits a first point.
`timescale 1ns / 1ps

module geohash_delta_varint_encoder
    import gdv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CHARS_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    logic     push_valid;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop_valid;
    logic     pop_ready;
    q_entry_t pop_entry;

    // Code builder and stream state.
    gdv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    // Entry queue.
    gdv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Byte generator.
    gdv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- tb/sv/gdv_stream_checker.sv -----
// Stream checker: predicts the encoded byte stream and compares it with the output channel.
`timescale 1ns / 1ps

module gdv_stream_checker
    import gdv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CHARS_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_word_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_word_t          m_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 point_count,
    output int                 restart_count,
    output int                 byte_count
);

    // Mirror of the block's state and precision register.
    logic                 first_pending;
    logic [CODE_BITS-1:0] last_code;
    logic [CHARS_W-1:0]   precision;

    // Bytes still owed by the block, oldest first.
    out_word_t pending_bytes[$];

    int errors;
    int points;
    int restarts;
    int bytes_seen;

    // Geohash bisection: code bits alternate longitude and latitude, longitude first,
    // each taken from the top of its fraction downward.
    function automatic logic [CODE_BITS-1:0] geohash_code(
        input logic [FIELD_BITS-1:0] lat,
        input logic [FIELD_BITS-1:0] lon,
        input logic [CHARS_W-1:0]    chars
    );
        int                   n_chars;
        int                   lon_i;
        int                   lat_i;
        int                   pos;
        int                   k;
        logic                 b;
        logic [CODE_BITS-1:0] code;
        n_chars = chars;
        if (n_chars < 1) begin
            n_chars = 1;
        end
        if (n_chars > MAX_CHARS) begin
            n_chars = MAX_CHARS;
        end
        code  = '0;
        lon_i = 0;
        lat_i = 0;
        for (k = 0; k < n_chars * CHAR_BITS; k++) begin
            if (k % 2 == 0) begin
                pos = FRACTION_BITS - 1 - lon_i;
                b = (pos >= 0 && pos < FIELD_BITS) ? lon[pos] : 1'b0;
                lon_i++;
            end else begin
                pos = FRACTION_BITS - 1 - lat_i;
                b = (pos >= 0 && pos < FIELD_BITS) ? lat[pos] : 1'b0;
                lat_i++;
            end
            code = {code[CODE_BITS-2:0], b};
        end
        return code;
    endfunction

    // Append one expected byte behind those already owed.
    function automatic void owe_byte(input out_word_t ob);
        pending_bytes.insert(pending_bytes.size(), ob);
    endfunction

    // Queue the bytes that one accepted word should produce and update the state.
    function automatic void encode_point(input in_word_t w);
        logic [CODE_BITS-1:0] code;
        logic [63:0]          wide;
        logic [63:0]          diff;
        logic [63:0]          zz;
        out_word_t            ob;
        int                   i;
        if (w.op == OP_RESTART) begin
            first_pending = 1'b1;
            last_code     = '0;
            restarts++;
            return;
        end
        points++;
        code = geohash_code(w.lat_fraction, w.lon_fraction, precision);
        if (first_pending) begin
            // Header byte, then seven code bytes, low byte first.
            ob.out_byte  = HEADER_BYTE;
            ob.last_byte = 1'b0;
            owe_byte(ob);
            wide = 64'(code);
            for (i = 0; i < FULL_BYTES - 1; i++) begin
                ob.out_byte  = wide[8*i +: 8];
                ob.last_byte = (i == FULL_BYTES - 2);
                owe_byte(ob);
            end
            first_pending = 1'b0;
        end else begin
            // Zigzag the difference, then emit seven-bit groups low first.
            diff = 64'(code) - 64'(last_code);
            zz   = (diff << 1) ^ {64{diff[63]}};
            i    = 0;
            do begin
                ob.out_byte = {1'b0, zz[6:0]};
                zz = zz >> 7;
                if (zz != 0) begin
                    ob.out_byte[7] = 1'b1;
                end
                ob.last_byte = (zz == 0);
                owe_byte(ob);
                i++;
            end while (zz != 0 && i < FULL_BYTES);
        end
        last_code = code;
    endfunction

    // Watch both channels and the register port on every rising edge.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            first_pending = 1'b1;
            last_code     = '0;
            precision     = CHARS_RESET;
            pending_bytes.delete();
        end else begin
            // Output side first: a byte can only answer a word accepted earlier.
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (pending_bytes.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: unexpected byte %02h last %0b with nothing pending",
                                 $realtime, m_data.out_byte, m_data.last_byte);
                    end
                    errors++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (want.out_byte !== m_data.out_byte ||
                        want.last_byte !== m_data.last_byte) begin
                        if (errors < 10) begin
                            $display({"%0t: byte mismatch, expected %02h last %0b,",
                                      " got %02h last %0b"},
                                     $realtime, want.out_byte, want.last_byte,
                                     m_data.out_byte, m_data.last_byte);
                        end
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                precision = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                encode_point(s_data);
            end
        end
        fail_count    <= errors;
        pending_count <= pending_bytes.size();
        point_count   <= points;
        restart_count <= restarts;
        byte_count    <= bytes_seen;
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the geohash delta varint encoder.
`timescale 1ns / 1ps

module tb;
    import gdv_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 16;
    localparam int PHASE_WORDS  = 17;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CHARS_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_word_t           s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_word_t          m_data;

    int fail_count;
    int pending_count;
    int point_count;
    int restart_count;
    int byte_count;

    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int settings_used = 1;

    logic [FIELD_BITS-1:0] trail_lat = '0;
    logic [FIELD_BITS-1:0] trail_lon = '0;

    // Precision settings visited after the reset value, out-of-range codes included.
    logic [CHARS_W-1:0] precision_plan [PHASES] =
        '{4'd1, 4'd0, 4'd5, 4'd15, 4'd12, 4'd7, 4'd11, 4'd3,
          4'd13, 4'd14, 4'd9, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10};

    geohash_delta_varint_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    gdv_stream_checker stream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .point_count   (point_count),
        .restart_count (restart_count),
        .byte_count    (byte_count)
    );

    // 4 ns clock.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Receiver: ready drops in bursts at the current stall rate.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("no word moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Offer one word, with an optional gap before it, and hold it until accepted.
    task automatic send_word(
        input logic                  op,
        input logic [FIELD_BITS-1:0] lat,
        input logic [FIELD_BITS-1:0] lon
    );
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_data.op           = op;
        s_data.lat_fraction = lat;
        s_data.lon_fraction = lon;
        s_valid             = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_ENCODE) begin
            trail_lat = lat;
            trail_lon = lon;
        end
    endtask

    // Stop sending and wait until the block owes nothing and has gone quiet.
    task automatic settle();
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_chars(input logic [CHARS_W-1:0] chars);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = chars;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly trajectory points near the last one, some jumps, a few restarts.
    task automatic random_word();
        int                    pick;
        logic [FIELD_BITS-1:0] lat_mask;
        logic [FIELD_BITS-1:0] lon_mask;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            send_word(OP_RESTART, $urandom, $urandom);
        end else if (pick < 35) begin
            send_word(OP_ENCODE, $urandom, $urandom);
        end else begin
            lat_mask = (32'h1 << $urandom_range(0, 31)) - 32'h1;
            lon_mask = (32'h1 << $urandom_range(0, 31)) - 32'h1;
            send_word(OP_ENCODE,
                      trail_lat + ($urandom & lat_mask) - ($urandom & lat_mask),
                      trail_lon + ($urandom & lon_mask) - ($urandom & lon_mask));
        end
    endtask

    initial begin
        int ph;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed words at the reset precision of 11 characters.
        gap_pct   = 20;
        stall_pct = 20;
        send_word(OP_ENCODE, 32'h0, 32'h0);
        send_word(OP_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ENCODE, 32'h0, 32'h0);
        send_word(OP_ENCODE, 32'h0, 32'h0);
        // Lowest code bit up and down: deltas of plus and minus one.
        send_word(OP_ENCODE, 32'h0, 32'h10);
        send_word(OP_ENCODE, 32'h0, 32'h0);
        send_word(OP_ENCODE, 32'h0, 32'h400);
        send_word(OP_ENCODE, 32'h40, 32'h400);
        send_word(OP_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_RESTART, 32'h0, 32'h0);
        send_word(OP_RESTART, 32'h0, 32'h0);
        send_word(OP_ENCODE, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(OP_ENCODE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(OP_ENCODE, 32'h8000_0000, 32'h8000_0000);
        send_word(OP_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(OP_ENCODE, 32'h0000_000F, 32'h0000_000F);
        send_word(OP_ENCODE, 32'h0, 32'h0);

        // Random phases, each at a new precision; the stream is not restarted
        // between phases, so precision changes also land mid-stream.
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            write_chars(precision_plan[ph]);
            settings_used++;
            if (ph >= PHASES - 2) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            repeat (PHASE_WORDS) random_word();
        end

        settle();
        $display("Covered %0d points and %0d restarts at %0d precision settings;",
                 point_count, restart_count, settings_used);
        $display("%0d bytes checked.", byte_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- geohash_delta_varint_encoder.f -----
sv/gdv_pkg.sv
sv/gdv_front.sv
sv/gdv_queue.sv
sv/gdv_back.sv
sv/geohash_delta_varint_encoder.sv
tb/sv/gdv_stream_checker.sv
tb/sv/tb.sv
